@@ sv/hsec_pkg.sv @@
// hsec_pkg: shared types, constants and a helper function for the hamming sec codec
// used by hamming_sec_encode_correct; no dependencies
package hsec_pkg;

    // fixed field widths of the item channels
    localparam int DATA_IN_W   = 26;
    localparam int CODE_IN_W   = 31;
    localparam int CODE_OUT_W  = 31;
    localparam int SYN_OUT_W   = 5;
    localparam int DATA_BITS_W = 5;

    // default data length limit
    localparam int MAX_DATA_DEFAULT = 26;

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_DATA_BITS  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_ODD_PARITY = 1'b1;

    // reset values of the registers
    localparam logic [DATA_BITS_W-1:0] DATA_BITS_RESET = 5'd4;

    // operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    // input item
    typedef struct packed {
        logic                 op;
        logic [DATA_IN_W-1:0] data_in;
        logic [CODE_IN_W-1:0] received_in;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [CODE_OUT_W-1:0] code_out;
        logic [SYN_OUT_W-1:0]  syndrome;
        logic                  error_found;
        logic                  position_invalid;
    } out_item_t;

    // smallest parity count r with d + r + 1 <= 2^r
    function automatic int parity_count(int d);
        int r;
        r = 0;
        while (r < 7 && d + r + 1 > (1 << r)) begin
            r++;
        end
        return r;
    endfunction

endpackage

@@ sv/hamming_sec_encode_correct.sv @@
// hamming_sec_encode_correct: top level of the hamming single-error-correcting codec
// depends on hsec_pkg for item types, register codes and the parity count function
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one item: op selects encode
//   (data_in -> codeword) or check (received_in -> syndrome and corrected word).
//   Result channel m_valid/m_ready/m_data returns one item per input item, in order.
//   The APB-style port sets data_bits (address 0) and odd_parity (address 4);
//   write it only while no item is in flight. pready is always high.
// Pipeline and throughput:
//   An accepted item sits in the input register while the xor trees work, and the
//   result register, which drives m_data, loads the result once it has room.
//   One item per cycle is sustained while m_ready stays high; the rate is set by
//   the single xor-tree stage.
// Reset (aresetn low, synchronous): both stages empty, data_bits = 4, even parity.
// Stall: while m_ready is low the result register holds its item, the input
//   register still takes one more item, and s_ready drops once both are full.
module hamming_sec_encode_correct #(
    parameter int MAX_DATA = hsec_pkg::MAX_DATA_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input item channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  hsec_pkg::in_item_t         s_data,
    // result item channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output hsec_pkg::out_item_t        m_data,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hsec_pkg::PADDR_W-1:0] paddr,
    input  logic [hsec_pkg::PDATA_W-1:0] pwdata,
    output logic [hsec_pkg::PDATA_W-1:0] prdata,
    output logic                       pready
);
    import hsec_pkg::*;

    // derived sizes
    localparam int RMAX   = parity_count(MAX_DATA);
    localparam int CODE_W = MAX_DATA + RMAX;
    localparam int DW     = $clog2(MAX_DATA + 1);
    localparam int RW     = $clog2(RMAX + 1);
    localparam int NW     = $clog2(CODE_W + 1);
    localparam int SYN_W  = RMAX;
    localparam int DCMP_W = (DW > DATA_BITS_W) ? DW : DATA_BITS_W;
    localparam int SCMP_W = (SYN_W > NW) ? SYN_W : NW;

    // positions covered by parity check k
    function automatic logic [CODE_W-1:0] cover_mask(int k);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int p = 1; p <= CODE_W; p++) begin
            m[p-1] = ((p >> k) & 1) == 1;
        end
        return m;
    endfunction

    // configuration registers
    logic [DATA_BITS_W-1:0] data_bits_reg;
    logic                   odd_parity_reg;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_bits_reg  <= DATA_BITS_RESET;
            odd_parity_reg <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_DATA_BITS:  data_bits_reg  <= pwdata[DATA_BITS_W-1:0];
                REG_ODD_PARITY: odd_parity_reg <= pwdata[0];
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            REG_DATA_BITS:  prdata = PDATA_W'(data_bits_reg);
            REG_ODD_PARITY: prdata = PDATA_W'(odd_parity_reg);
        endcase
    end

    // handshake and pipeline control
    in_item_t  in_item_reg;
    logic      in_valid_reg, in_valid_next;
    out_item_t out_item_reg, out_item_next;
    logic      m_valid_reg, m_valid_next;
    logic      out_room;
    logic      in_take;

    assign out_room = !m_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_room;
    assign in_take  = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_item_reg;

    always_comb begin
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (out_room) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        m_valid_next = out_room ? in_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg <= s_data;
        end
        if (out_room && in_valid_reg) begin
            out_item_reg <= out_item_next;
        end
    end

    // effective data length, parity count and word length
    logic [DCMP_W-1:0] db_ext;
    logic [DCMP_W-1:0] db_clamp;
    logic [DW-1:0]     d_eff;
    logic [RW-1:0]     r_eff;
    logic [NW-1:0]     n_eff;

    assign db_ext = DCMP_W'(data_bits_reg);

    always_comb begin
        if (db_ext == '0) begin
            db_clamp = DCMP_W'(1);
        end else if (db_ext > DCMP_W'(MAX_DATA)) begin
            db_clamp = DCMP_W'(MAX_DATA);
        end else begin
            db_clamp = db_ext;
        end
        d_eff = DW'(db_clamp);
    end

    // smallest candidate wins, so scan from the top down
    always_comb begin
        r_eff = RW'(RMAX);
        for (int k = RMAX; k >= 0; k--) begin
            if (int'(d_eff) + k + 1 <= (1 << k)) begin
                r_eff = RW'(k);
            end
        end
        n_eff = NW'(d_eff) + NW'(r_eff);
    end

    // data bits limited to the data length
    logic [DATA_IN_W-1:0] data_masked;
    always_comb begin
        for (int i = 0; i < DATA_IN_W; i++) begin
            data_masked[i] = in_item_reg.data_in[i] && (i < int'(d_eff));
        end
    end

    // scatter data into the non-power-of-two positions, mask the received word
    logic [CODE_W-1:0] scat;
    logic [CODE_W-1:0] rx;
    genvar gp;
    generate
        for (gp = 1; gp <= CODE_W; gp++) begin : g_pos
            localparam int DI = gp - 1 - $clog2(gp + 1);
            if ((gp & (gp - 1)) == 0 || DI >= DATA_IN_W) begin : g_nodata
                assign scat[gp-1] = 1'b0;
            end else begin : g_data
                assign scat[gp-1] = data_masked[DI];
            end
            if (gp <= CODE_IN_W) begin : g_rx
                assign rx[gp-1] = in_item_reg.received_in[gp-1] && (gp <= int'(n_eff));
            end else begin : g_norx
                assign rx[gp-1] = 1'b0;
            end
        end
    endgenerate

    // parity xor trees, one per check
    logic [RMAX-1:0] enc_par;
    logic [RMAX-1:0] chk_par;
    genvar gk;
    generate
        for (gk = 0; gk < RMAX; gk++) begin : g_par
            localparam logic [CODE_W-1:0] COVER = cover_mask(gk);
            assign enc_par[gk] = (^(scat & COVER)) ^ odd_parity_reg;
            assign chk_par[gk] = (^(rx & COVER)) ^ odd_parity_reg;
        end
    endgenerate

    // encoded word: parity bits at power-of-two positions below the word length
    logic [CODE_W-1:0] enc_word;
    always_comb begin
        enc_word = scat;
        for (int k = 0; k < RMAX; k++) begin
            if (enc_par[k] && k < int'(r_eff)) begin
                enc_word[(1 << k) - 1] = 1'b1;
            end
        end
    end

    // syndrome, range check and single-bit correction
    logic [SYN_W-1:0]  syn;
    logic              syn_nz;
    logic              syn_inval;
    logic [CODE_W-1:0] fixed_word;
    always_comb begin
        for (int k = 0; k < RMAX; k++) begin
            syn[k] = chk_par[k] && (k < int'(r_eff));
        end
        syn_nz    = |syn;
        syn_inval = syn_nz && (SCMP_W'(syn) > SCMP_W'(n_eff));
        for (int i = 0; i < CODE_W; i++) begin
            fixed_word[i] = rx[i] ^ (syn_nz && !syn_inval && syn == SYN_W'(i + 1));
        end
    end

    // select by operation
    logic [CODE_W-1:0] res_word;
    logic [SYN_W-1:0]  res_syn;
    assign res_word = (in_item_reg.op == OP_CHECK) ? fixed_word : enc_word;
    assign res_syn  = (in_item_reg.op == OP_CHECK) ? syn : '0;

    // fit internal widths to the result fields
    genvar go;
    generate
        for (go = 0; go < CODE_OUT_W; go++) begin : g_code_out
            if (go < CODE_W) begin : g_bit
                assign out_item_next.code_out[go] = res_word[go];
            end else begin : g_zero
                assign out_item_next.code_out[go] = 1'b0;
            end
        end
        for (go = 0; go < SYN_OUT_W; go++) begin : g_syn_out
            if (go < SYN_W) begin : g_bit
                assign out_item_next.syndrome[go] = res_syn[go];
            end else begin : g_zero
                assign out_item_next.syndrome[go] = 1'b0;
            end
        end
    endgenerate

    assign out_item_next.error_found      = (in_item_reg.op == OP_CHECK) && syn_nz;
    assign out_item_next.position_invalid = (in_item_reg.op == OP_CHECK) && syn_inval;

    // an invalid position is always reported as an error
    a_inval_is_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.position_invalid || m_data.error_found))
        else $error("position_invalid without error_found");

    // encode items leave the result register with clear status
    a_encode_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_room && in_valid_reg && in_item_reg.op == OP_ENCODE) |=>
        (!m_data.error_found && !m_data.position_invalid && m_data.syndrome == '0))
        else $error("encode item with nonzero status");

    // an accepted item always lands in the input register
    a_take_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> in_valid_reg)
        else $error("accepted item lost at the input register");

    // a blocked input register keeps its item
    a_hold_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_room) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input register changed while blocked");

endmodule
